[rtl/ccd_pkg.sv]
// shared types, constants and helper functions for the candle detector
`default_nettype none

package ccd_pkg;

    localparam int MAX_PERIOD      = 64;
    localparam int WINDOW_HARD_MAX = 126;

    localparam int PRICE_W = 32;
    localparam int THR_W   = 14;
    localparam int WIN_W   = 7;
    localparam int CNT_W   = 7;
    localparam int SIG_W   = 2;
    localparam int CFG_W   = 14;

    // price scale: the threshold is in hundredths of a percent
    localparam logic [THR_W-1:0] SCALE = THR_W'(10000);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // register indexes on the config port
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW    = 1'b1;

    // result codes
    localparam logic [SIG_W-1:0] SIG_NONE = 2'b00;
    localparam logic [SIG_W-1:0] SIG_BULL = 2'b01;
    localparam logic [SIG_W-1:0] SIG_BEAR = 2'b11;

    // bar colour from the classifier stage
    typedef struct packed {
        logic bull;
        logic bear;
    } bar_class_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + CNT_W'(1);
    endfunction

    // zero means one, then clip to the period limit and to what the counter can exceed
    function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        int unsigned wv;
        wv = int'(w);
        if (wv == 0)
            wv = 1;
        if (wv > MAX_PERIOD)
            wv = MAX_PERIOD;
        if (wv > WINDOW_HARD_MAX)
            wv = WINDOW_HARD_MAX;
        eff_window = CNT_W'(wv);
    endfunction

endpackage

`default_nettype wire

[rtl/ccd_classify.sv]
// bar classifier: registered price products, then the bull and bear compares
`default_nettype none

module ccd_classify (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic [ccd_pkg::PRICE_W-1:0] open_price,
    input  wire logic [ccd_pkg::PRICE_W-1:0] close_price,
    input  wire logic [ccd_pkg::THR_W-1:0]   change_threshold,
    output ccd_pkg::bar_class_t              bar_class
);
    import ccd_pkg::*;

    localparam int LHS_W  = PRICE_W + THR_W;       // close * scale
    localparam int FAC_W  = THR_W + 1;             // scale +/- threshold
    localparam int BULL_W = PRICE_W + FAC_W;
    localparam int BEAR_W = PRICE_W + 1 + FAC_W;   // signed product

    logic        [FAC_W-1:0]  bull_fac;
    logic signed [FAC_W-1:0]  bear_fac;
    logic        [LHS_W-1:0]  lhs_next;
    logic        [BULL_W-1:0] bull_next;
    logic signed [BEAR_W-1:0] bear_next;

    logic        [LHS_W-1:0]  lhs_reg;
    logic        [BULL_W-1:0] bull_reg;
    logic signed [BEAR_W-1:0] bear_reg;

    always_comb
    begin
        bull_fac  = {1'b0, SCALE} + {1'b0, change_threshold};
        // goes negative for thresholds above the scale, so nothing is bearish
        bear_fac  = $signed({1'b0, SCALE}) - $signed({1'b0, change_threshold});
        lhs_next  = LHS_W'(close_price) * LHS_W'(SCALE);
        bull_next = BULL_W'(open_price) * BULL_W'(bull_fac);
        bear_next = $signed({1'b0, open_price}) * bear_fac;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lhs_reg  <= lhs_next;
            bull_reg <= bull_next;
            bear_reg <= bear_next;
        end
    end

    always_comb
    begin
        bar_class.bear = $signed({2'b00, lhs_reg}) < bear_reg;
        bar_class.bull = !bar_class.bear && ({1'b0, lhs_reg} > bull_reg);
    end

endmodule

`default_nettype wire

[rtl/consecutive_candle_detector_unit.sv]
// top level of the consecutive candle detector: handshake, run counters, signal
`default_nettype none

// channel   | direction | payload
// ----------+-----------+---------------------------------------------------
// s_*       | in        | tdata: open_price[31:0], close_price[63:32];
//           |           | tuser: series_start
// m_*       | out       | tdata: candle_signal[1:0] (signed), zeros above
// cfg_*     | in        | index 0 change_threshold, index 1 window_length
//
// one bar per cycle when the output side keeps up:
// the first stage holds the three price products, the second compares
// them, updates the runs and lands the signal in the output register.
// the run state lives in the second stage only, so nothing waits on it.
// reset clears the valids, runs and config (threshold 0, window 3).
// a stall on m_tready fills the output, then the product stage, then drops s_tready.

module consecutive_candle_detector_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // bar input
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [63:0]                s_tdata,   // open_price, close_price
    input  wire logic                       s_tuser,   // series_start
    // signal output
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // candle_signal, pad
    // config writes
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [ccd_pkg::CFG_W-1:0]  cfg_data
);
    import ccd_pkg::*;

    // config registers
    logic [THR_W-1:0] threshold_reg;
    logic [WIN_W-1:0] window_reg;

    // pipeline control
    logic s1_valid_reg;
    logic s1_start_reg;
    logic out_valid_reg;
    logic out_en;
    logic s1_en;
    logic s2_fire;

    // run state
    logic [CNT_W-1:0] bull_run_reg;
    logic [CNT_W-1:0] bear_run_reg;
    logic [CNT_W-1:0] bars_seen_reg;
    logic [CNT_W-1:0] bull_run_next;
    logic [CNT_W-1:0] bear_run_next;
    logic [CNT_W-1:0] bars_seen_next;
    logic [CNT_W-1:0] bull_base;
    logic [CNT_W-1:0] bear_base;
    logic [CNT_W-1:0] bars_base;
    logic [CNT_W-1:0] win;

    logic [SIG_W-1:0] sig_next;
    logic [SIG_W-1:0] sig_reg;

    bar_class_t bar_class;

    // output register frees when empty or taken; product stage frees when it moves on
    assign out_en   = !out_valid_reg || m_tready;
    assign s1_en    = !s1_valid_reg || out_en;
    assign s_tready = s1_en;
    assign s2_fire  = s1_valid_reg && out_en;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - SIG_W){1'b0}}, sig_reg};

    // config port; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            window_reg    <= WIN_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_WINDOW:    window_reg    <= cfg_data[WIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // stage one: price products
    ccd_classify u_classify (
        .clk              (clk),
        .load             (s1_en),
        .open_price       (s_tdata[31:0]),
        .close_price      (s_tdata[63:32]),
        .change_threshold (threshold_reg),
        .bar_class        (bar_class)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_start_reg <= s_tuser;
    end

    // stage two: run update and signal
    always_comb
    begin
        win       = eff_window(window_reg);
        // series start clears the runs before this bar counts
        bull_base = s1_start_reg ? '0 : bull_run_reg;
        bear_base = s1_start_reg ? '0 : bear_run_reg;
        bars_base = s1_start_reg ? '0 : bars_seen_reg;

        if (bar_class.bear)
        begin
            bear_run_next = sat_inc(bear_base);
            bull_run_next = '0;
        end
        else if (bar_class.bull)
        begin
            bull_run_next = sat_inc(bull_base);
            bear_run_next = '0;
        end
        else
        begin
            // neutral bar breaks both runs
            bull_run_next = '0;
            bear_run_next = '0;
        end
        bars_seen_next = sat_inc(bars_base);

        // warm-up: stay quiet until more than a window of bars is in
        sig_next = SIG_NONE;
        if (bars_seen_next > win)
        begin
            if (bull_run_next >= win)
                sig_next = SIG_BULL;
            else if (bear_run_next >= win)
                sig_next = SIG_BEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bull_run_reg  <= '0;
            bear_run_reg  <= '0;
            bars_seen_reg <= '0;
        end
        else if (s2_fire)
        begin
            bull_run_reg  <= bull_run_next;
            bear_run_reg  <= bear_run_next;
            bars_seen_reg <= bars_seen_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
            sig_reg <= sig_next;
    end

endmodule

`default_nettype wire

[tb/sv/consecutive_candle_detector_unit_tb.sv]
// self-checking testbench for the consecutive candle detector: random bars, stalls, config sweep
`default_nettype none

module consecutive_candle_detector_unit_tb;
    import ccd_pkg::*;

    // shapes of bar the stimulus can build against the current threshold
    typedef enum int {
        BAR_BULL,
        BAR_BEAR,
        BAR_FLAT,
        BAR_EDGE_UP,
        BAR_EDGE_DOWN,
        BAR_NOISE
    } bar_kind_t;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PHASE_BARS     = 170;
    localparam int     PHASES         = 8;
    localparam longint PRICE_SCALE    = 10000;

    // predicts candle_signal per accepted bar and checks the output transfers
    class candle_signal_board;
        logic [THR_W-1:0] threshold;
        logic [WIN_W-1:0] window;
        logic [CNT_W-1:0] bull_len;
        logic [CNT_W-1:0] bear_len;
        logic [CNT_W-1:0] seen;
        logic [SIG_W-1:0] signals_due[$];
        int               mismatches;

        function new();
            threshold  = '0;
            window     = WIN_W'(3);
            bull_len   = '0;
            bear_len   = '0;
            seen       = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_THRESHOLD)
                threshold = value[THR_W-1:0];
            else
                window = value[WIN_W-1:0];
        endfunction

        function int pending();
            return signals_due.size();
        endfunction

        function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
            return (v == COUNT_MAX) ? v : v + CNT_W'(1);
        endfunction

        function void note_bar(logic [PRICE_W-1:0] open_p, logic [PRICE_W-1:0] close_p,
                               logic first);
            longint           lhs;
            longint           bear_bound;
            longint           bull_bound;
            longint           thr;
            int               w;
            logic [SIG_W-1:0] sig;
            thr        = longint'({50'd0, threshold});
            lhs        = longint'({32'd0, close_p}) * PRICE_SCALE;
            bear_bound = longint'({32'd0, open_p}) * (PRICE_SCALE - thr);
            bull_bound = longint'({32'd0, open_p}) * (PRICE_SCALE + thr);
            w = int'(window);
            if (w == 0)
                w = 1;
            if (w > MAX_PERIOD)
                w = MAX_PERIOD;
            if (w > WINDOW_HARD_MAX)
                w = WINDOW_HARD_MAX;
            if (first)
            begin
                bull_len = '0;
                bear_len = '0;
                seen     = '0;
            end
            if (lhs < bear_bound)
            begin
                bear_len = count_up(bear_len);
                bull_len = '0;
            end
            else if (lhs > bull_bound)
            begin
                bull_len = count_up(bull_len);
                bear_len = '0;
            end
            else
            begin
                bull_len = '0;
                bear_len = '0;
            end
            seen = count_up(seen);
            sig  = SIG_NONE;
            if (int'(seen) > w)
            begin
                if (int'(bull_len) >= w)
                    sig = SIG_BULL;
                else if (int'(bear_len) >= w)
                    sig = SIG_BEAR;
            end
            signals_due.push_back(sig);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_signal(logic [SIG_W-1:0] got);
            logic [SIG_W-1:0] want;
            if (signals_due.size() == 0)
                report_mismatch($sformatf("candle_signal %b with no bar pending", got));
            else
            begin
                want = signals_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("candle_signal %b, predicted %b", got, want));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;    // open_price, close_price
    logic                 s_tuser;    // series_start
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;    // candle_signal, pad
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int                   sender_idle_pct;
    int                   receiver_stall_pct;
    int                   quiet_cycles;
    candle_signal_board   board;

    consecutive_candle_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // output side: random back-pressure, new decision every falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    // result transfers are checked at the edge that moves them; the watchdog
    // counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_signal(m_tdata[SIG_W-1:0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // one bar transfer; the sender may sit idle a random number of cycles first
    task automatic send_bar(logic [PRICE_W-1:0] open_p, logic [PRICE_W-1:0] close_p,
                            logic first);
        logic placed;
        placed = 1'b0;
        while (!placed)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < sender_idle_pct)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {close_p, open_p};
                s_tuser  <= first;
                placed = 1'b1;
            end
        end
        do
            @(posedge clk);
        while (!s_tready);
        board.note_bar(open_p, close_p, first);
    endtask

    // drop valid and let the pipeline drain before touching the registers
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] win);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= REG_WINDOW;
        cfg_data  <= win;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.write_reg(REG_THRESHOLD, thr);
        board.write_reg(REG_WINDOW, win);
    endtask

    // build prices that land in the wanted class under the current threshold
    function automatic void shape_bar(input bar_kind_t kind, output logic [PRICE_W-1:0] open_p,
                                      output logic [PRICE_W-1:0] close_p);
        longint thr;
        longint bound;
        longint k;
        thr     = longint'({50'd0, board.threshold});
        open_p  = PRICE_W'($urandom_range(1, 1000000000));
        close_p = open_p;
        case (kind)
            BAR_BULL:
            begin
                bound   = longint'({32'd0, open_p}) * (PRICE_SCALE + thr);
                close_p = PRICE_W'(bound / PRICE_SCALE + 1 + longint'($urandom_range(0, 1000)));
            end
            BAR_BEAR:
            begin
                // no bear is possible once the threshold reaches the scale
                bound = longint'({32'd0, open_p}) * (PRICE_SCALE - thr);
                if (bound > 0)
                begin
                    k       = (bound - 1) / PRICE_SCALE;
                    close_p = PRICE_W'(k - longint'($urandom_range(0, 1000)) % (k + 1));
                end
            end
            BAR_EDGE_UP:
            begin
                // close lands exactly on the bullish bound: neutral
                k       = longint'($urandom_range(1, 160000));
                open_p  = PRICE_W'(k * PRICE_SCALE);
                close_p = PRICE_W'(k * (PRICE_SCALE + thr));
            end
            BAR_EDGE_DOWN:
            begin
                k      = longint'($urandom_range(1, 160000));
                open_p = PRICE_W'(k * PRICE_SCALE);
                if (thr <= PRICE_SCALE)
                    close_p = PRICE_W'(k * (PRICE_SCALE - thr));
                else
                    close_p = open_p;
            end
            BAR_NOISE:
            begin
                open_p  = $urandom;
                close_p = $urandom;
            end
            default:
                close_p = open_p;
        endcase
    endfunction

    // mostly same-colour runs around the window length, some noise and edges
    task automatic run_bars(int count);
        int                 sent;
        int                 pick;
        int                 len;
        int                 span;
        bar_kind_t          kind;
        logic               first;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] close_p;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 63);
            span = (int'(board.window) > MAX_PERIOD) ? MAX_PERIOD : int'(board.window);
            len  = $urandom_range(1, span + 3);
            if (pick == 0)
            begin
                // long run to push the counters into saturation
                kind = ($urandom_range(0, 1) == 0) ? BAR_BULL : BAR_BEAR;
                len  = $urandom_range(100, 140);
            end
            else if (pick <= 6)
            begin
                kind = BAR_NOISE;
                len  = $urandom_range(1, 4);
            end
            else if (pick <= 9)
                kind = BAR_EDGE_UP;
            else if (pick <= 12)
                kind = BAR_EDGE_DOWN;
            else if (pick <= 16)
                kind = BAR_FLAT;
            else
                kind = (pick[0]) ? BAR_BULL : BAR_BEAR;
            if (kind == BAR_EDGE_UP || kind == BAR_EDGE_DOWN || kind == BAR_FLAT)
                len = $urandom_range(1, 3);
            first = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++)
            begin
                shape_bar(kind, open_p, close_p);
                if (kind == BAR_NOISE)
                    send_bar(open_p, close_p, $urandom_range(0, 1) == 1);
                else
                    send_bar(open_p, close_p, first && (i == 0));
                sent++;
            end
        end
    endtask

    // threshold and window per phase; the last two are drawn at random
    int unsigned phase_thr[PHASES] = '{0, 10000, 16383, 0, 75, 9999, 0, 0};
    int unsigned phase_win[PHASES] = '{1, 64, 127, 0, 5, 65, 3, 3};

    initial
    begin
        board              = new();
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = 1'b0;
        m_tready           = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_THRESHOLD;
        cfg_data           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        quiet_cycles       = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed bars under the reset settings (threshold 0, window 3)
        send_bar(32'd0, 32'd0, 1'b1);                 // zero prices, equal test
        send_bar(32'd0, 32'hFFFF_FFFF, 1'b0);         // bullish from zero open
        send_bar(32'hFFFF_FFFF, 32'd0, 1'b0);         // bearish to zero close
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // flat at the top
        repeat (4) send_bar(32'd100, 32'd200, 1'b0);  // bullish run reaches the window
        send_bar(32'd200, 32'd100, 1'b0);             // one bear breaks it
        // new series: warm-up holds the signal at zero for the first three bars
        send_bar(32'd100, 32'd200, 1'b1);
        repeat (3) send_bar(32'd100, 32'd200, 1'b0);
        repeat (4) send_bar(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_bar(32'd5000, 32'd5000, 1'b0);           // neutral bar clears both runs

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase >= PHASES - 2)
            begin
                phase_thr[phase] = $urandom_range(0, 16383);
                phase_win[phase] = $urandom_range(0, 127);
            end
            write_regs(CFG_W'(phase_thr[phase]), CFG_W'(phase_win[phase]));
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 69;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 69;
                end
                default:
                begin
                    sender_idle_pct    = 37;
                    receiver_stall_pct = 37;
                end
            endcase
            run_bars(PHASE_BARS);
        end

        settle();
        repeat (4) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[consecutive_candle_detector_unit.f]
rtl/ccd_pkg.sv
rtl/ccd_classify.sv
rtl/consecutive_candle_detector_unit.sv
tb/sv/consecutive_candle_detector_unit_tb.sv
